[src/sobel_edge_magnitude_assert.svh]
// Assertion macros for the Sobel edge magnitude block.
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define SEM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define SEM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SEM_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SEM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/sem_pkg.sv]
// Types, constants and the Sobel kernel function of the edge magnitude block.
package sem_pkg;

   // Line store depth default and the fixed height limit.
   localparam int unsigned MAX_WIDTH_DEFAULT = 1024;
   localparam int unsigned MAX_HEIGHT        = 1024;

   // Field widths.
   localparam int unsigned PIXEL_W     = 8;
   localparam int unsigned MAG_W       = 11;
   localparam int unsigned POS_W       = 10;
   localparam int unsigned ROW_W       = 11;
   localparam int unsigned CSR_DATA_W  = 11;
   localparam int unsigned CSR_INDEX_W = 2;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] THRESHOLD_RESET = 11'd0;
   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET     = 11'd1024;
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET    = 11'd1024;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EDGE_THRESHOLD = 2'd0,
      CSR_IMAGE_WIDTH    = 2'd1,
      CSR_IMAGE_HEIGHT   = 2'd2
   } csr_index_type;

   // One result record as held in the result queue.
   typedef struct packed {
      logic [MAG_W-1:0] magnitude;
      logic             edge_res;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             last_of_frame;
   } result_type;

   // L1 Sobel magnitude over three columns (left, middle, right; top to bottom).
   function automatic logic [MAG_W-1:0] sobel_mag(
      input logic [PIXEL_W-1:0] l0, input logic [PIXEL_W-1:0] l1,
      input logic [PIXEL_W-1:0] l2, input logic [PIXEL_W-1:0] m0,
      input logic [PIXEL_W-1:0] m2, input logic [PIXEL_W-1:0] r0,
      input logic [PIXEL_W-1:0] r1, input logic [PIXEL_W-1:0] r2);
      logic signed [11:0] gx;
      logic signed [11:0] gy;
      logic signed [11:0] ax;
      logic signed [11:0] ay;
      gx = ($signed({4'b0, r0}) - $signed({4'b0, l0}))
         + (($signed({4'b0, r1}) - $signed({4'b0, l1})) <<< 1)
         + ($signed({4'b0, r2}) - $signed({4'b0, l2}));
      gy = ($signed({4'b0, l2}) - $signed({4'b0, l0}))
         + (($signed({4'b0, m2}) - $signed({4'b0, m0})) <<< 1)
         + ($signed({4'b0, r2}) - $signed({4'b0, r0}));
      ax = (gx < 0) ? -gx : gx;
      ay = (gy < 0) ? -gy : gy;
      return ax[MAG_W-1:0] + ay[MAG_W-1:0];
   endfunction

endpackage

[src/sobel_edge_magnitude.sv]
// Streaming 3x3 Sobel edge detector with L1 magnitude and line-store memories.
//
//  Channel  Ports                                  Direction  Moves
//  req      req_valid, req_stall, req_pixel/flush  in         one pixel per transaction
//  rsp      rsp_valid, rsp_stall, rsp_magnitude..  out        one result per transaction
//  csr      csr_valid, csr_ready, csr_index/data   in         one register write
//
//  One pixel is taken per cycle while req_stall is low; a result passes stage one and the result queue.
//  The line stores are read at acceptance and written back as the pixel leaves stage one, so
//  the single read port and single write port of each store keep the rate of one pixel a cycle.
//  After reset a clearing pass zeroes every address of both line stores; req_stall is high.
//  req_stall also rises while a pixel waits in stage one because the four-entry result queue
//  holds three or more results.

`include "sobel_edge_magnitude_assert.svh"

module sobel_edge_magnitude #(
   parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Pixel input channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sem_pkg::PIXEL_W-1:0]      req_pixel,
   input  logic                             req_flush,
   // Result output channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sem_pkg::MAG_W-1:0]        rsp_magnitude,
   output logic                             rsp_edge_res,
   output logic [sem_pkg::POS_W-1:0]        rsp_out_row,
   output logic [sem_pkg::POS_W-1:0]        rsp_out_col,
   output logic                             rsp_last_of_frame,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sem_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sem_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sem_pkg::*;

   localparam int unsigned CW      = $clog2(MAX_WIDTH);
   localparam int unsigned WW      = CW + 1;
   localparam int unsigned QDEPTH  = 4;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = QPTR_W + 1;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] threshold_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;

   // Line stores and their registered read data.
   logic [PIXEL_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] upper_rd_ff;
   logic [PIXEL_W-1:0] middle_rd_ff;

   // Clearing pass after reset.
   logic          clearing_ff;
   logic          clearing_in;
   logic [CW-1:0] clear_addr_ff;
   logic [CW-1:0] clear_addr_in;

   // Input position counters.
   logic [CW-1:0]    in_col_ff;
   logic [CW-1:0]    in_col_in;
   logic [ROW_W-1:0] in_row_ff;
   logic [ROW_W-1:0] in_row_in;

   // Stage one: item whose line-store data is being read.
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic [CW-1:0]      s1_col_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic               s1_last_ff;
   logic               s1_fire;

   // Window of the two previous columns: [0..2] column c-2, [3..5] column c-1.
   logic [PIXEL_W-1:0] win_ff [6];

   // Result queue.
   result_type         q_ff [QDEPTH];
   logic [QPTR_W-1:0]  q_wr_ff;
   logic [QPTR_W-1:0]  q_wr_in;
   logic [QPTR_W-1:0]  q_rd_ff;
   logic [QPTR_W-1:0]  q_rd_in;
   logic [QCNT_W-1:0]  q_count_ff;
   logic [QCNT_W-1:0]  q_count_in;
   logic [1:0]         q_push;
   logic               q_pop;

   // Front-end decode.
   logic [WW-1:0]      w_eff;
   logic [ROW_W-1:0]   h_eff;
   logic [CW-1:0]      cur_col;
   logic               cur_pad;
   logic               cur_last;
   logic [PIXEL_W-1:0] cur_pix;
   logic               req_accept;

   // Stage-one datapath.
   logic [PIXEL_W-1:0] col_r [3];
   logic               emit_left;
   logic               emit_right;
   logic [ROW_W-1:0]   res_row;
   logic [CW-1:0]      res_col_left;
   logic [MAG_W-1:0]   mag_left;
   logic [MAG_W-1:0]   mag_right;
   result_type         res_left;
   result_type         res_right;

   // Line-store write port.
   logic               mem_we;
   logic [CW-1:0]      mem_waddr;
   logic [PIXEL_W-1:0] upper_wdata;
   logic [PIXEL_W-1:0] middle_wdata;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EDGE_THRESHOLD: threshold_ff <= csr_data;
            CSR_IMAGE_WIDTH:    width_ff     <= csr_data;
            CSR_IMAGE_HEIGHT:   height_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Width and height in use, clamped to their legal ranges.
   always_comb begin
      if (width_ff < 11'd2) begin
         w_eff = WW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_ff);
      end
      if (height_ff < 11'd1) begin
         h_eff = ROW_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // Position of the incoming pixel and the next position.
   always_comb begin
      if ({1'b0, in_col_ff} >= w_eff) begin
         cur_col = CW'(w_eff - WW'(1));
      end else begin
         cur_col = in_col_ff;
      end
      cur_pad  = (in_row_ff >= h_eff);
      cur_last = ({1'b0, cur_col} == (w_eff - WW'(1)));
      cur_pix  = (cur_pad || req_flush) ? '0 : req_pixel;
      if (cur_last) begin
         in_col_in = '0;
         in_row_in = cur_pad ? '0 : (in_row_ff + ROW_W'(1));
      end else begin
         in_col_in = cur_col + CW'(1);
         in_row_in = in_row_ff;
      end
   end

   // Handshake and stage-one advance.
   assign s1_fire     = s1_valid_ff && (q_count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_stall   = clearing_ff || (s1_valid_ff && !s1_fire);
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   // Clearing pass sequencing.
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + CW'(1);
         if (clear_addr_ff == CW'(MAX_WIDTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         if (req_accept) begin
            in_col_ff <= in_col_in;
            in_row_ff <= in_row_in;
         end
      end
   end

   // Stage-one payload, captured with the line-store read.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_col_ff  <= cur_col;
         s1_row_ff  <= in_row_ff;
         s1_pix_ff  <= cur_pix;
         s1_last_ff <= cur_last;
      end
   end

   // Line-store read port: one read per accepted transaction.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         upper_rd_ff  <= upper_mem[cur_col];
         middle_rd_ff <= middle_mem[cur_col];
      end
   end

   // Right column of the window; rows above the image read as zero.
   always_comb begin
      col_r[0] = (s1_row_ff >= ROW_W'(2)) ? upper_rd_ff : '0;
      col_r[1] = (s1_row_ff >= ROW_W'(1)) ? middle_rd_ff : '0;
      col_r[2] = s1_pix_ff;
   end

   // Line-store write port: clearing pass or write-back of stage one.
   always_comb begin
      mem_we       = clearing_ff || s1_fire;
      mem_waddr    = clearing_ff ? clear_addr_ff : s1_col_ff;
      upper_wdata  = clearing_ff ? '0 : col_r[1];
      middle_wdata = clearing_ff ? '0 : s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         upper_mem[mem_waddr]  <= upper_wdata;
         middle_mem[mem_waddr] <= middle_wdata;
      end
   end

   // Sliding window update.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i]     <= (s1_col_ff == '0) ? '0 : win_ff[3 + i];
            win_ff[3 + i] <= col_r[i];
         end
      end
   end

   // Magnitudes for the pixel left of the current one, and for the row end.
   always_comb begin
      mag_left  = sobel_mag(win_ff[0], win_ff[1], win_ff[2], win_ff[3], win_ff[5],
                            col_r[0], col_r[1], col_r[2]);
      mag_right = sobel_mag(win_ff[3], win_ff[4], win_ff[5], col_r[0], col_r[2],
                            '0, '0, '0);
      emit_left    = (s1_col_ff != '0) && (s1_row_ff >= ROW_W'(1));
      emit_right   = emit_left && s1_last_ff;
      res_row      = s1_row_ff - ROW_W'(1);
      res_col_left = s1_col_ff - CW'(1);

      res_left.magnitude     = mag_left;
      res_left.edge_res      = (mag_left > threshold_ff);
      res_left.out_row       = res_row[POS_W-1:0];
      res_left.out_col       = POS_W'(res_col_left);
      res_left.last_of_frame = (res_row == h_eff - ROW_W'(1))
                               && ({1'b0, res_col_left} == (w_eff - WW'(1)));

      res_right.magnitude     = mag_right;
      res_right.edge_res      = (mag_right > threshold_ff);
      res_right.out_row       = res_row[POS_W-1:0];
      res_right.out_col       = POS_W'(s1_col_ff);
      res_right.last_of_frame = (res_row == h_eff - ROW_W'(1))
                                && ({1'b0, s1_col_ff} == (w_eff - WW'(1)));
   end

   // Result queue bookkeeping.
   always_comb begin
      q_push = 2'd0;
      if (s1_fire && emit_left) begin
         q_push = emit_right ? 2'd2 : 2'd1;
      end
      q_pop      = rsp_valid && !rsp_stall;
      q_wr_in    = q_wr_ff + QPTR_W'(q_push);
      q_rd_in    = q_rd_ff + QPTR_W'(q_pop);
      q_count_in = q_count_ff + QCNT_W'(q_push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff    <= '0;
         q_rd_ff    <= '0;
         q_count_ff <= '0;
      end else begin
         q_wr_ff    <= q_wr_in;
         q_rd_ff    <= q_rd_in;
         q_count_ff <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push != 2'd0) begin
         q_ff[q_wr_ff] <= res_left;
      end
      if (q_push == 2'd2) begin
         q_ff[q_wr_ff + QPTR_W'(1)] <= res_right;
      end
   end

   // Result channel driven from the queue head.
   assign rsp_valid         = (q_count_ff != '0);
   assign rsp_magnitude     = q_ff[q_rd_ff].magnitude;
   assign rsp_edge_res      = q_ff[q_rd_ff].edge_res;
   assign rsp_out_row       = q_ff[q_rd_ff].out_row;
   assign rsp_out_col       = q_ff[q_rd_ff].out_col;
   assign rsp_last_of_frame = q_ff[q_rd_ff].last_of_frame;

   // Checks on the clearing pass, the queue and the stage-one hold.
   `SEM_ASSERT_IMPLY(a_no_accept_clearing, clock, reset, clearing_ff, !req_accept, "pixel taken during clearing pass")
   `SEM_ASSERT_ALWAYS(a_queue_bound, clock, reset, q_count_ff <= QCNT_W'(QDEPTH), "result queue overflow")
   `SEM_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_col_ff), "held pixel lost")
   `SEM_ASSERT_NEXT(a_clear_once, clock, reset, !clearing_ff, !clearing_ff, "clearing pass restarted")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the Sobel edge magnitude block.
module tb_top;

   typedef sem_pkg::result_type result_type;

   // One column of the 3x3 window: [0] top, [1] middle, [2] bottom.
   typedef logic [2:0][7:0] column_type;

   typedef enum logic {
      STEP_ITEM,
      STEP_CSR
   } step_kind_type;

   // One row of the directed stimulus table.
   typedef struct packed {
      step_kind_type kind;
      logic [7:0]    pixel;
      logic          flush;
      logic [1:0]    csr_index;
      logic [10:0]   csr_data;
      logic          typed;
      logic [1:0]    n_typed;
      result_type    res0;
      result_type    res1;
   } stim_step_type;

   localparam int unsigned LINE_DEPTH    = sem_pkg::MAX_WIDTH_DEFAULT;
   localparam logic [1:0]  CSR_NO_REG    = 2'd3;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          RANDOM_ITEMS  = 1580;
   localparam int          IDLE_OFF_AT   = 1350;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          MAX_PRINTED   = 100;
   localparam int          WIDE_EXTRA    = 40;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_pixel   = 8'd0;
   logic        req_flush   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [10:0] rsp_magnitude;
   logic        rsp_edge_res;
   logic [9:0]  rsp_out_row;
   logic [9:0]  rsp_out_col;
   logic        rsp_last_of_frame;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = 2'd0;
   logic [10:0] csr_data    = 11'd0;

   // Predictor copy of the registers and of the block state.
   logic [10:0] cfg_threshold = sem_pkg::THRESHOLD_RESET;
   logic [10:0] cfg_width     = sem_pkg::WIDTH_RESET;
   logic [10:0] cfg_height    = sem_pkg::HEIGHT_RESET;
   logic [7:0]  line_upper [LINE_DEPTH];
   logic [7:0]  line_middle[LINE_DEPTH];
   column_type  win_left   = '0;
   column_type  win_mid    = '0;
   logic [10:0] pos_row    = '0;
   int unsigned pos_col    = 0;

   result_type    pending[$];
   stim_step_type steps[$];
   int            mismatch_count = 0;
   bit            idle_off = 1'b0;
   bit            hold_rsp = 1'b0;

   sobel_edge_magnitude i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel         (req_pixel),
      .req_flush         (req_flush),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_magnitude     (rsp_magnitude),
      .rsp_edge_res      (rsp_edge_res),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // The clock runs with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The line stores start out cleared, as the block clears them after reset.
   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_upper[i]  = 8'd0;
         line_middle[i] = 8'd0;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("mismatch at %0t ns: %s", $time, msg);
      end
   endtask

   // L1 norm of the horizontal and vertical Sobel responses over three columns.
   function automatic int unsigned l1_gradient(input column_type lf, input column_type md,
                                               input column_type rt);
      int gx;
      int gy;
      gx = (int'(rt[0]) - int'(lf[0])) + 2 * (int'(rt[1]) - int'(lf[1]))
         + (int'(rt[2]) - int'(lf[2]));
      gy = (int'(lf[2]) - int'(lf[0])) + 2 * (int'(md[2]) - int'(md[0]))
         + (int'(rt[2]) - int'(rt[0]));
      if (gx < 0) gx = -gx;
      if (gy < 0) gy = -gy;
      return (gx + gy) & 32'h7FF;
   endfunction

   function automatic result_type make_result(input int unsigned mag, input int unsigned row,
                                              input int unsigned col, input int unsigned w,
                                              input int unsigned h);
      result_type rec;
      rec.magnitude     = mag[10:0];
      rec.edge_res      = (mag > cfg_threshold);
      rec.out_row       = row[9:0];
      rec.out_col       = col[9:0];
      rec.last_of_frame = (row == h - 1) && (col == w - 1);
      return rec;
   endfunction

   function automatic result_type res(input int unsigned mag, input logic mark,
                                      input int unsigned row, input int unsigned col,
                                      input logic last);
      result_type r;
      r.magnitude     = mag[10:0];
      r.edge_res      = mark;
      r.out_row       = row[9:0];
      r.out_col       = col[9:0];
      r.last_of_frame = last;
      return r;
   endfunction

   // Advance the predicted state by one pixel and return the results it releases.
   task automatic predict_pixel(input logic [7:0] pix, input logic flg, output int n,
                                output result_type r0, output result_type r1);
      int unsigned w;
      int unsigned h;
      int unsigned r;
      int unsigned c;
      logic        pad;
      logic        last_c;
      logic [7:0]  p;
      column_type  right;
      column_type  zero_col;
      zero_col = '0;
      w = 32'(cfg_width);
      if (w < 2) w = 2;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      h = 32'(cfg_height);
      if (h < 1) h = 1;
      if (h > sem_pkg::MAX_HEIGHT) h = sem_pkg::MAX_HEIGHT;
      r = 32'(pos_row);
      c = pos_col;
      if (c >= w) c = w - 1;
      pad    = (r >= h);
      last_c = (c == w - 1);
      p      = (pad || flg) ? 8'd0 : pix;

      // Rows above the top of the image read as zero.
      right[0] = (r >= 2) ? line_upper[c] : 8'd0;
      right[1] = (r >= 1) ? line_middle[c] : 8'd0;
      right[2] = p;
      line_upper[c]  = right[1];
      line_middle[c] = p;

      n  = 0;
      r0 = '0;
      r1 = '0;
      if (c == 0) begin
         win_left = '0;
         win_mid  = right;
      end else begin
         if (r >= 1) begin
            r0 = make_result(l1_gradient(win_left, win_mid, right), r - 1, c - 1, w, h);
            n  = 1;
            // The last column of the row above has padding to its right.
            if (last_c) begin
               r1 = make_result(l1_gradient(win_mid, right, zero_col), r - 1, c, w, h);
               n  = 2;
            end
         end
         win_left = win_mid;
         win_mid  = right;
      end

      if (last_c) begin
         pos_col = 0;
         pos_row = pad ? 11'd0 : 11'(r + 1);
      end else begin
         pos_col = c + 1;
         pos_row = r[10:0];
      end
   endtask

   // Offer one pixel transaction, predict it on acceptance, then maybe leave a gap.
   task automatic send_pixel(input logic [7:0] pix, input logic flg, input logic typed,
                             input logic [1:0] n_typed, input result_type t0,
                             input result_type t1);
      int         n;
      result_type r0;
      result_type r1;
      int         gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_pixel = pix;
      req_flush = flg;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_pixel(pix, flg, n, r0, r1);
      if (typed) begin
         if (n_typed >= 1) pending.push_back(t0);
         if (n_typed >= 2) pending.push_back(t1);
      end else begin
         if (n >= 1) pending.push_back(r0);
         if (n >= 2) pending.push_back(r1);
      end
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [10:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         sem_pkg::CSR_EDGE_THRESHOLD: cfg_threshold = data;
         sem_pkg::CSR_IMAGE_WIDTH:    cfg_width     = data;
         sem_pkg::CSR_IMAGE_HEIGHT:   cfg_height    = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Stop offering pixels and wait until the block has nothing left in flight.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic add_item(input logic [7:0] pix, input logic flg);
      stim_step_type s;
      s       = '0;
      s.kind  = STEP_ITEM;
      s.pixel = pix;
      s.flush = flg;
      steps.push_back(s);
   endtask

   task automatic add_typed(input logic [7:0] pix, input logic flg, input logic [1:0] n,
                            input result_type t0, input result_type t1);
      stim_step_type s;
      s         = '0;
      s.kind    = STEP_ITEM;
      s.pixel   = pix;
      s.flush   = flg;
      s.typed   = 1'b1;
      s.n_typed = n;
      s.res0    = t0;
      s.res1    = t1;
      steps.push_back(s);
   endtask

   task automatic add_csr(input logic [1:0] idx, input logic [10:0] data);
      stim_step_type s;
      s           = '0;
      s.kind      = STEP_CSR;
      s.csr_index = idx;
      s.csr_data  = data;
      steps.push_back(s);
   endtask

   function automatic logic [7:0] pick_pixel();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [10:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 11'd0;
         1:       return 11'd2040;
         2:       return 11'd2047;
         default: return 11'($urandom_range(0, 1200));
      endcase
   endfunction

   task automatic check_field(input string name, input logic [10:0] got,
                              input logic [10:0] want, input result_type exp);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d, expected %0d (row %0d, col %0d)",
                                   name, got, want, exp.out_row, exp.out_col));
      end
   endtask

   // Every accepted result transaction is checked against the oldest expectation.
   always @(posedge clock) begin : result_monitor
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (row %0d, col %0d)",
                                      rsp_out_row, rsp_out_col));
         end else begin
            want = pending.pop_front();
            check_field("magnitude", rsp_magnitude, want.magnitude, want);
            check_field("edge_res", 11'(rsp_edge_res), 11'(want.edge_res), want);
            check_field("out_row", 11'(rsp_out_row), 11'(want.out_row), want);
            check_field("out_col", 11'(rsp_out_col), 11'(want.out_col), want);
            check_field("last_of_frame", 11'(rsp_last_of_frame),
                        11'(want.last_of_frame), want);
         end
      end
   end

   // The result side stalls in short bursts, and once for a long stretch on request.
   initial begin : result_stall
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall = 1'b1;
            for (int k = 0; k < HOLD_CYCLES; k++) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(20, 60)
                                              : $urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // Hard limit on the run time.
   initial begin : run_limit
      #12000000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      stim_step_type s;
      int            ph;
      int            random_items;
      int            mode;
      int            count;
      int            total;
      int unsigned   w_eff;
      int unsigned   h_eff;
      logic [10:0]   w_reg;
      logic [10:0]   h_reg;
      logic [10:0]   thr;
      bit            flush_noise;
      bit            noise;
      logic [7:0]    pix;
      logic          flg;
      int            waited;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Two pixels at the reset settings stay in the first row and give nothing.
      add_item(8'd255, 1'b0);
      add_item(8'd0, 1'b0);
      // Shrinking the width mid-row ends the row; the padding row follows.
      add_csr(sem_pkg::CSR_IMAGE_WIDTH, 11'd2);
      add_csr(sem_pkg::CSR_IMAGE_HEIGHT, 11'd1);
      add_csr(sem_pkg::CSR_EDGE_THRESHOLD, 11'd509);
      add_item(8'd7, 1'b0);
      add_item(8'd0, 1'b1);
      add_item(8'd0, 1'b1);
      // A 2x1 frame of full-scale pixels just above the threshold.
      add_typed(8'd255, 1'b0, 2'd0, '0, '0);
      add_typed(8'd255, 1'b0, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd2, res(510, 1'b1, 0, 0, 1'b0), res(510, 1'b1, 0, 1, 1'b1));
      // A high threshold of 2040; nonzero pixels on the padding row are ignored.
      add_csr(sem_pkg::CSR_EDGE_THRESHOLD, 11'd2040);
      add_typed(8'd255, 1'b0, 2'd0, '0, '0);
      add_typed(8'd255, 1'b0, 2'd0, '0, '0);
      add_typed(8'd255, 1'b0, 2'd0, '0, '0);
      add_typed(8'd255, 1'b0, 2'd2, res(510, 1'b0, 0, 0, 1'b0), res(510, 1'b0, 0, 1, 1'b1));
      // Zero threshold against a black frame: zero does not exceed zero.
      add_csr(sem_pkg::CSR_EDGE_THRESHOLD, 11'd0);
      add_typed(8'd0, 1'b0, 2'd0, '0, '0);
      add_typed(8'd0, 1'b0, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd2, res(0, 1'b0, 0, 0, 1'b0), res(0, 1'b0, 0, 1, 1'b1));
      // Zero width and height clamp to 2x1; a flush inside the image reads as zero.
      add_csr(sem_pkg::CSR_IMAGE_WIDTH, 11'd0);
      add_csr(sem_pkg::CSR_IMAGE_HEIGHT, 11'd0);
      add_csr(sem_pkg::CSR_EDGE_THRESHOLD, 11'd3);
      add_typed(8'd5, 1'b0, 2'd0, '0, '0);
      add_typed(8'd200, 1'b1, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd0, '0, '0);
      add_typed(8'd0, 1'b1, 2'd2, res(0, 1'b0, 0, 0, 1'b0), res(10, 1'b1, 0, 1, 1'b1));

      for (int i = 0; i < steps.size(); i++) begin
         s = steps[i];
         if (s.kind == STEP_CSR) begin
            settle();
            csr_write(s.csr_index, s.csr_data);
         end else begin
            send_pixel(s.pixel, s.flush, s.typed, s.n_typed, s.res0, s.res1);
         end
      end

      // Random phases: mostly whole frames, some cut short, some noise.
      ph           = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         settle();
         thr         = pick_threshold();
         flush_noise = ($urandom_range(0, 6) == 0);
         noise       = 1'b0;
         mode        = 0;
         if (ph == 0) begin
            w_reg = 11'd16;
            h_reg = 11'd6;
         end else if (ph == 1) begin
            // One full row at the widest width, given through an out-of-range width.
            w_reg = 11'd2047;
            h_reg = 11'd0;
         end else if (ph == 2) begin
            w_reg = 11'd2;
            h_reg = 11'd2047;
            mode  = 1;
         end else begin
            w_reg = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(13, 70))
                                                : 11'($urandom_range(2, 12));
            h_reg = 11'($urandom_range(1, 5));
            case ($urandom_range(0, 19))
               0, 1, 2: mode = 1;
               3, 4: begin
                  mode  = 2;
                  noise = 1'b1;
                  w_reg = 11'($urandom_range(0, 2047));
                  h_reg = 11'($urandom_range(0, 2047));
               end
               default: mode = 0;
            endcase
         end
         csr_write(sem_pkg::CSR_EDGE_THRESHOLD, thr);
         csr_write(sem_pkg::CSR_IMAGE_WIDTH, w_reg);
         csr_write(sem_pkg::CSR_IMAGE_HEIGHT, h_reg);
         if (noise && $urandom_range(0, 1) == 0) begin
            csr_write(CSR_NO_REG, 11'($urandom_range(0, 2047)));
         end
         if (ph == 0) hold_rsp = 1'b1;

         w_eff = (w_reg < 2) ? 2 : (w_reg > LINE_DEPTH) ? LINE_DEPTH : w_reg;
         h_eff = (h_reg < 1) ? 1 : (h_reg > sem_pkg::MAX_HEIGHT) ? sem_pkg::MAX_HEIGHT : h_reg;
         if (mode == 2) begin
            count = $urandom_range(1, 30);
         end else if (ph == 1) begin
            // The wide row and the start of the padding row below it.
            count = w_eff + WIDE_EXTRA;
         end else if (ph == 2) begin
            count = 90;
         end else begin
            total = (h_eff + 1) * w_eff;
            count = (mode == 1) ? $urandom_range(1, total - 1) : total;
         end

         for (int k = 0; k < count; k++) begin
            pix = pick_pixel();
            if (noise) begin
               flg = 1'($urandom_range(0, 1));
            end else if (k / w_eff < h_eff) begin
               flg = flush_noise && ($urandom_range(0, 19) == 0);
            end else begin
               flg = ($urandom_range(0, 7) != 0);
            end
            send_pixel(pix, flg, 1'b0, 2'd0, '0, '0);
            random_items++;
            if (random_items >= IDLE_OFF_AT) idle_off = 1'b1;
         end
         ph++;
      end

      // Drain the results still in flight, with a bound.
      @(negedge clock);
      req_valid = 1'b0;
      waited    = 0;
      while (pending.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (pending.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived", pending.size()));
      end

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
